// ===== sv/itba_pkg.sv =====
package itba_pkg;

   // Field widths
   localparam int TIME_W     = 32;
   localparam int WIDTH_W    = 31;
   localparam int BIN_W      = 40;
   localparam int READ_BIN_W = 10;
   localparam int FRAC_BITS  = 16;
   localparam int FRAC_W     = FRAC_BITS + 1;
   localparam int DELTA_W    = FRAC_W + 1;
   localparam int STEP_W     = 6;

   // Store depth default
   localparam int NUM_BINS_DEFAULT = 1024;

   // Divider step counts: full bin index, and sixteen fraction bits
   localparam logic [STEP_W-1:0] DIV_STEPS_BIN  = STEP_W'(TIME_W);
   localparam logic [STEP_W-1:0] DIV_STEPS_FRAC = STEP_W'(FRAC_BITS);

   // One whole bin as a Q16 fraction
   localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_REFERENCE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_WIDTH      = CSR_INDEX_W'(1);
   localparam logic [WIDTH_W-1:0]     BIN_WIDTH_RESET    = WIDTH_W'(65536);

   // Operation codes
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DIV_A,
      ST_DIV_B,
      ST_RANGE,
      ST_FRAC_A,
      ST_FRAC_B,
      ST_READ,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                start;
      logic [TIME_W-1:0]   dividend;
      logic [WIDTH_W-1:0]  rem_init;
      logic [STEP_W-1:0]   steps;
   } div_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [TIME_W-1:0]   quot;
      logic [WIDTH_W-1:0]  rem;
   } div_rsp_type;

   typedef struct packed {
      logic rd;
      logic wr;
      logic clear;
   } store_cmd_type;

endpackage

// ===== sv/itba_if.sv =====
interface itba_req_if;
   import itba_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         op;
   logic signed [TIME_W-1:0]     first_time;
   logic signed [TIME_W-1:0]     second_time;
   logic                         subtract;
   logic [READ_BIN_W-1:0]        read_bin;

   modport source (output valid, op, first_time, second_time, subtract, read_bin,
                   input ready);
   modport sink   (input valid, op, first_time, second_time, subtract, read_bin,
                   output ready);
endinterface

interface itba_rsp_if;
   import itba_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         status;
   logic signed [BIN_W-1:0]      bin_value;

   modport source (output valid, status, bin_value, input ready);
   modport sink   (input valid, status, bin_value, output ready);
endinterface

// ===== sv/itba_div.sv =====
module itba_div (
   input  logic                          clock,
   input  logic                          reset,
   input  itba_pkg::div_req_type         req,
   input  logic [itba_pkg::WIDTH_W-1:0]  divisor,
   output itba_pkg::div_rsp_type         rsp
);
   import itba_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [WIDTH_W-1:0]  rem_ff, rem_in;
   logic [TIME_W-1:0]   qd_ff, qd_in;

   logic [WIDTH_W:0]    shifted;
   logic [WIDTH_W+1:0]  diff;
   logic                q_bit;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, qd_ff[TIME_W-1]};
      diff    = {1'b0, shifted} - {2'b00, divisor};
      q_bit   = ~diff[WIDTH_W+1];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      qd_in   = qd_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.steps;
         rem_in  = req.rem_init;
         qd_in   = req.dividend;
      end else if (busy_ff) begin
         rem_in = q_bit ? diff[WIDTH_W-1:0] : shifted[WIDTH_W-1:0];
         qd_in  = {qd_ff[TIME_W-2:0], q_bit};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      qd_ff  <= qd_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = qd_ff;
   assign rsp.rem  = rem_ff;

   // The partial remainder stays below the divisor throughout a division
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < divisor))
      else $error("divider remainder not below divisor");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!busy_ff && $past(busy_ff)))
      else $error("divider done without a finished division");

endmodule

// ===== sv/itba_store.sv =====
module itba_store #(
   parameter int NUM_BINS = itba_pkg::NUM_BINS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  itba_pkg::store_cmd_type             cmd,
   input  logic [$clog2(NUM_BINS)-1:0]         addr,
   input  logic signed [itba_pkg::DELTA_W-1:0] delta,
   output logic signed [itba_pkg::BIN_W-1:0]   rd_data
);
   import itba_pkg::*;

   localparam logic signed [BIN_W-1:0] BIN_MAX = {1'b0, {(BIN_W-1){1'b1}}};
   localparam logic signed [BIN_W-1:0] BIN_MIN = {1'b1, {(BIN_W-1){1'b0}}};

   logic signed [BIN_W-1:0] mem_ff [NUM_BINS];
   logic signed [BIN_W-1:0] rd_data_ff;
   logic signed [BIN_W:0]   sum_wide;
   logic signed [BIN_W-1:0] wr_value;

   // Add the delta to the word read last cycle and clamp to the Q23.16 range
   always_comb begin
      sum_wide = (BIN_W+1)'(rd_data_ff) + (BIN_W+1)'(delta);
      if (cmd.clear) begin
         wr_value = '0;
      end else if (sum_wide[BIN_W] != sum_wide[BIN_W-1]) begin
         wr_value = sum_wide[BIN_W] ? BIN_MIN : BIN_MAX;
      end else begin
         wr_value = sum_wide[BIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem_ff[addr] <= wr_value;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

   a_single_port: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd && cmd.wr))
      else $error("store read and written in one cycle");

   a_clear_is_write: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> cmd.wr)
      else $error("store clear without write");

   // Read data must belong to the read issued just before a write
   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr && !cmd.clear) |-> ($past(cmd.rd) && $past(addr) == addr))
      else $error("store update without a read of the same word");

endmodule

// ===== sv/interval_to_time_bin_accumulator.sv =====
// Channel  Dir  Handshake     Word
// req_ch   in   valid/ready   op, first_time, second_time, subtract, read_bin
// rsp_ch   out  valid/ready   status, bin_value
// csr_*    in   write enable  csr_index, csr_write_data (no read-back)
//
// Reset is synchronous; a clearing pass then zeroes every bin in turn.
// A read passes ST_READ, where the store is read, then ST_FINISH, where the word is loaded.
// For an add one shared divider finds both bin indexes and then the end fractions (one
// fraction division fewer when the later end fills its bin or both ends share one), then
// each bin is a read and a write on the single store port. req_ch.ready is high only
// between items; a word held by rsp_ch.ready stalls the next item in its last cycle.
module interval_to_time_bin_accumulator #(
   parameter int NUM_BINS = itba_pkg::NUM_BINS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   itba_req_if.sink                              req_ch,
   itba_rsp_if.source                            rsp_ch,
   input  logic                                  csr_write_enable,
   input  logic [itba_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [itba_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import itba_pkg::*;

   localparam int AW = $clog2(NUM_BINS);

   state_type state_ff, state_in;

   // Configuration
   logic signed [TIME_W-1:0] tref_ff;
   logic [WIDTH_W-1:0]       width_ff;

   // Item held during the work
   logic                     op_ff;
   logic                     neg_ff;
   logic [READ_BIN_W-1:0]    read_bin_ff;
   logic signed [TIME_W-1:0] late_ff;
   logic signed [TIME_W-1:0] early_ff;
   logic                     status_ff;

   // Working values
   logic [TIME_W-1:0]        dist_b_ff;
   logic [TIME_W-1:0]        qa_ff, qb_ff;
   logic [WIDTH_W-1:0]       ra_ff, rb_ff;
   logic                     same_ff;
   logic [FRAC_W-1:0]        frac_a_ff, frac_b_ff;
   logic [AW-1:0]            ca_ff, cb_ff, cur_ff, clr_ff;

   // Output register
   logic                     rsp_valid_ff;
   logic                     rsp_status_ff;
   logic signed [BIN_W-1:0]  rsp_value_ff;

   logic                     accept;
   logic                     rsp_load;
   logic [TIME_W:0]          dist_a, dist_b;
   logic                     check_bad;
   logic                     range_out;
   logic                     same_bin;
   logic                     full_a;
   logic [TIME_W-1:0]        read_bin_wide;
   logic                     read_out;
   logic [FRAC_W-1:0]        mag;
   logic signed [DELTA_W-1:0] delta;

   div_req_type              div_req;
   div_rsp_type              div_rsp;
   store_cmd_type            store_cmd;
   logic [AW-1:0]            store_addr;
   logic signed [BIN_W-1:0]  store_rd_data;

   itba_div u_div (
      .clock   (clock),
      .reset   (reset),
      .req     (div_req),
      .divisor (width_ff),
      .rsp     (div_rsp)
   );

   itba_store #(.NUM_BINS(NUM_BINS)) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (store_cmd),
      .addr    (store_addr),
      .delta   (delta),
      .rd_data (store_rd_data)
   );

   // Decode conditions used by the sequencer
   always_comb begin
      accept        = req_ch.valid && req_ch.ready;
      rsp_load      = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);
      dist_a        = {tref_ff[TIME_W-1], tref_ff} - {late_ff[TIME_W-1], late_ff};
      dist_b        = {tref_ff[TIME_W-1], tref_ff} - {early_ff[TIME_W-1], early_ff};
      check_bad     = (width_ff == '0) || dist_a[TIME_W];
      range_out     = qb_ff >= TIME_W'(NUM_BINS);
      same_bin      = qa_ff == qb_ff;
      full_a        = ra_ff == '0;
      read_bin_wide = TIME_W'(read_bin_ff);
      read_out      = read_bin_wide >= TIME_W'(NUM_BINS);
   end

   // Pick the amount for the current bin: end fractions or a whole bin
   always_comb begin
      if (cur_ff == ca_ff) begin
         mag = frac_a_ff;
      end else if (cur_ff == cb_ff) begin
         mag = frac_b_ff;
      end else begin
         mag = FRAC_ONE;
      end
      delta = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_ff == AW'(NUM_BINS - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) state_in = (req_ch.op == OP_READ) ? ST_READ : ST_CHECK;
         end
         ST_CHECK:  state_in = check_bad ? ST_FINISH : ST_DIV_A;
         ST_DIV_A:  if (div_rsp.done) state_in = ST_DIV_B;
         ST_DIV_B:  if (div_rsp.done) state_in = ST_RANGE;
         ST_RANGE: begin
            if (range_out) begin
               state_in = ST_FINISH;
            end else if (!same_bin && full_a) begin
               state_in = ST_FRAC_B;
            end else begin
               state_in = ST_FRAC_A;
            end
         end
         ST_FRAC_A: begin
            if (div_rsp.done) state_in = same_ff ? ST_UPD_RD : ST_FRAC_B;
         end
         ST_FRAC_B: if (div_rsp.done) state_in = ST_UPD_RD;
         ST_READ:   state_in = ST_FINISH;
         ST_UPD_RD: state_in = ST_UPD_WR;
         ST_UPD_WR: state_in = (cur_ff == cb_ff) ? ST_FINISH : ST_UPD_RD;
         ST_FINISH: if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: divider starts, store commands, input ready
   always_comb begin
      div_req    = '0;
      store_cmd  = '0;
      store_addr = cur_ff;
      case (state_ff)
         ST_CLEAR: begin
            store_cmd.wr    = 1'b1;
            store_cmd.clear = 1'b1;
            store_addr      = clr_ff;
         end
         ST_CHECK: begin
            if (!check_bad) begin
               div_req.start    = 1'b1;
               div_req.dividend = dist_a[TIME_W-1:0];
               div_req.steps    = DIV_STEPS_BIN;
            end
         end
         ST_DIV_A: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = dist_b_ff;
               div_req.steps    = DIV_STEPS_BIN;
            end
         end
         ST_RANGE: begin
            if (!range_out) begin
               div_req.start = 1'b1;
               div_req.steps = DIV_STEPS_FRAC;
               if (same_bin) begin
                  div_req.rem_init = rb_ff - ra_ff;
               end else if (full_a) begin
                  div_req.rem_init = rb_ff;
               end else begin
                  div_req.rem_init = width_ff - ra_ff;
               end
            end
         end
         ST_FRAC_A: begin
            if (div_rsp.done && !same_ff) begin
               div_req.start    = 1'b1;
               div_req.rem_init = rb_ff;
               div_req.steps    = DIV_STEPS_FRAC;
            end
         end
         ST_READ: begin
            store_cmd.rd = !read_out;
            store_addr   = read_bin_wide[AW-1:0];
         end
         ST_UPD_RD: store_cmd.rd = 1'b1;
         ST_UPD_WR: store_cmd.wr = 1'b1;
         default: begin
         end
      endcase
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         tref_ff      <= '0;
         width_ff     <= BIN_WIDTH_RESET;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TIME_REFERENCE: tref_ff  <= csr_write_data;
               CSR_BIN_WIDTH:      width_ff <= csr_write_data[WIDTH_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      // Hold the item, later endpoint first
      if (accept) begin
         op_ff       <= req_ch.op;
         neg_ff      <= req_ch.subtract;
         read_bin_ff <= req_ch.read_bin;
         status_ff   <= 1'b0;
         if (req_ch.first_time >= req_ch.second_time) begin
            late_ff  <= req_ch.first_time;
            early_ff <= req_ch.second_time;
         end else begin
            late_ff  <= req_ch.second_time;
            early_ff <= req_ch.first_time;
         end
      end
      case (state_ff)
         ST_CHECK: begin
            dist_b_ff <= dist_b[TIME_W-1:0];
            status_ff <= check_bad;
         end
         ST_DIV_A: begin
            if (div_rsp.done) begin
               qa_ff <= div_rsp.quot;
               ra_ff <= div_rsp.rem;
            end
         end
         ST_DIV_B: begin
            if (div_rsp.done) begin
               qb_ff <= div_rsp.quot;
               rb_ff <= div_rsp.rem;
            end
         end
         ST_RANGE: begin
            status_ff <= range_out;
            same_ff   <= same_bin;
            ca_ff     <= qa_ff[AW-1:0];
            cb_ff     <= qb_ff[AW-1:0];
            cur_ff    <= qa_ff[AW-1:0];
            if (full_a) frac_a_ff <= FRAC_ONE;
         end
         ST_FRAC_A: begin
            if (div_rsp.done) frac_a_ff <= FRAC_W'(div_rsp.quot[FRAC_BITS-1:0]);
         end
         ST_FRAC_B: begin
            if (div_rsp.done) frac_b_ff <= FRAC_W'(div_rsp.quot[FRAC_BITS-1:0]);
         end
         ST_READ:   status_ff <= read_out;
         ST_UPD_WR: cur_ff    <= cur_ff + AW'(1);
         default: begin
         end
      endcase
      // Load the result word
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= (op_ff == OP_READ && !status_ff) ? store_rd_data : '0;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.bin_value = rsp_value_ff;

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("item accepted but sequencer stayed idle");

   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD_WR) |-> (cur_ff >= ca_ff && cur_ff <= cb_ff))
      else $error("bin update outside the interval");

   a_idle_div_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_rsp.busy)
      else $error("divider busy while sequencer idle");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result word raised outside finish");

endmodule
